/* rtl/core/cgbm_pkg.sv */
// Package for the curvilinear grid bilinear map block.
// Holds field widths, parameter defaults, codes, FSM state type and the
// command/status structs shared by controller, datapath and lanes.
package cgbm_pkg;

	localparam int MAX_NODES_DEF   = 64;
	localparam int COORD_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF   = 16;

	localparam int IDX_W      = 32;
	localparam int CELL_W     = 6;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 6;

	localparam logic [CELL_W-1:0] CELLS_RESET = 6'd63;

	localparam logic [CFG_IDX_W-1:0] CFG_CELLS_I = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CELLS_J = 1'd1;

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_MAP  = 1'b1;

	typedef enum logic [1:0] {
		RD_00,
		RD_10,
		RD_01,
		RD_11
	} rd_sel_t;

	typedef enum logic [2:0] {
		OPA_P00,
		OPA_P10,
		OPA_P01,
		OPA_A,
		OPA_B,
		OPA_C,
		OPA_TMP
	} opa_sel_t;

	typedef enum logic [1:0] {
		W_U,
		W_V,
		W_ONE_U,
		W_ONE_V
	} opw_sel_t;

	typedef enum logic [2:0] {
		ACC_NONE,
		ACC_CLR,
		ACC_P00,
		ACC_ADD,
		ACC_TMP
	} acc_op_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_RD00,
		ST_RD10,
		ST_RD01,
		ST_RD11,
		ST_WAIT,
		ST_DIFF,
		ST_AREG,
		ST_MA,
		ST_MB,
		ST_MT,
		ST_MC,
		ST_S1,
		ST_S2,
		ST_LAST,
		ST_ZERO,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic     capture;
		logic     write;
		logic     rd_en;
		rd_sel_t  rd_sel;
		logic     diff;
		logic     areg;
		opa_sel_t opa;
		opw_sel_t opw;
		acc_op_t  acc;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		logic u_zero;
		logic v_zero;
	} status_t;

endpackage

/* rtl/core/cgbm_if.sv */
// Channel interfaces of the grid map block: request word and result word.
// Depends on cgbm_pkg for the fixed field widths.
interface cgbm_req_if #(
	parameter int COORD_WIDTH = cgbm_pkg::COORD_WIDTH_DEF
);
	logic                              valid;
	logic                              ready;
	logic                              req_type;
	logic [cgbm_pkg::CELL_W-1:0]       node_col;
	logic [cgbm_pkg::CELL_W-1:0]       node_row;
	logic signed [COORD_WIDTH-1:0]     node_xcoord;
	logic signed [COORD_WIDTH-1:0]     node_ycoord;
	logic signed [cgbm_pkg::IDX_W-1:0] frac_i;
	logic signed [cgbm_pkg::IDX_W-1:0] frac_j;

	modport source (
		output valid, req_type, node_col, node_row, node_xcoord, node_ycoord, frac_i, frac_j,
		input  ready
	);
	modport sink (
		input  valid, req_type, node_col, node_row, node_xcoord, node_ycoord, frac_i, frac_j,
		output ready
	);
endinterface

interface cgbm_res_if #(
	parameter int COORD_WIDTH = cgbm_pkg::COORD_WIDTH_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] out_x;
	logic signed [COORD_WIDTH-1:0] out_y;
	logic                          in_range;

	modport source (
		output valid, out_x, out_y, in_range,
		input  ready
	);
	modport sink (
		input  valid, out_x, out_y, in_range,
		output ready
	);
endinterface

/* rtl/core/cgbm_ctrl.sv */
// Sequencer of the grid map block: handshakes, read and multiply schedule.
// Depends on cgbm_pkg for state, command and status types.
module cgbm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_is_map,
	input  logic              out_ready,
	input  cgbm_pkg::status_t status,
	output logic              in_ready,
	output logic              out_valid,
	output cgbm_pkg::cmd_t    cmd
);
	import cgbm_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid && in_is_map) state_d = ST_RD00;
			ST_RD00: state_d = ST_RD10;
			ST_RD10: state_d = ST_RD01;
			ST_RD01: state_d = ST_RD11;
			ST_RD11: state_d = ST_WAIT;
			ST_WAIT: begin
				if (status.u_zero && status.v_zero)
					state_d = ST_ZERO;
				else if (status.u_zero || status.v_zero)
					state_d = ST_S1;
				else
					state_d = ST_DIFF;
			end
			ST_DIFF: state_d = ST_AREG;
			ST_AREG: state_d = ST_MA;
			ST_MA:   state_d = ST_MB;
			ST_MB:   state_d = ST_MT;
			ST_MT:   state_d = ST_MC;
			ST_MC:   state_d = ST_LAST;
			ST_S1:   state_d = ST_S2;
			ST_S2:   state_d = ST_LAST;
			ST_LAST: state_d = ST_DONE;
			ST_ZERO: state_d = ST_DONE;
			ST_DONE: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready     = 1'b0;
		cmd.capture  = 1'b0;
		cmd.write    = 1'b0;
		cmd.rd_en    = 1'b0;
		cmd.rd_sel   = RD_00;
		cmd.diff     = 1'b0;
		cmd.areg     = 1'b0;
		cmd.opa      = OPA_P00;
		cmd.opw      = W_U;
		cmd.acc      = ACC_NONE;
		cmd.out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid && in_is_map;
				cmd.write   = in_valid && !in_is_map;
			end
			ST_RD00: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_00;
			end
			ST_RD10: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_10;
			end
			ST_RD01: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_01;
			end
			ST_RD11: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_11;
			end
			ST_WAIT: ;
			ST_DIFF: cmd.diff = 1'b1;
			ST_AREG: cmd.areg = 1'b1;
			ST_MA: begin
				cmd.opa = OPA_A;
				cmd.opw = W_U;
				cmd.acc = ACC_P00;
			end
			ST_MB: begin
				cmd.opa = OPA_B;
				cmd.opw = W_U;
				cmd.acc = ACC_TMP;
			end
			ST_MT: begin
				cmd.opa = OPA_TMP;
				cmd.opw = W_V;
				cmd.acc = ACC_ADD;
			end
			ST_MC: begin
				cmd.opa = OPA_C;
				cmd.opw = W_V;
				cmd.acc = ACC_ADD;
			end
			ST_S1: begin
				cmd.opa = status.v_zero ? OPA_P10 : OPA_P01;
				cmd.opw = status.v_zero ? W_U : W_V;
				cmd.acc = ACC_CLR;
			end
			ST_S2: begin
				cmd.opa = OPA_P00;
				cmd.opw = status.v_zero ? W_ONE_U : W_ONE_V;
				cmd.acc = ACC_ADD;
			end
			ST_LAST: cmd.acc = ACC_ADD;
			ST_ZERO: cmd.acc = ACC_P00;
			ST_DONE: cmd.out_load = out_free;
			default: ;
		endcase
	end

endmodule

/* rtl/core/cgbm_lane.sv */
// One coordinate lane: node store, corner registers, shared multiplier,
// accumulator and result register. Depends on cgbm_pkg for command types.
module cgbm_lane #(
	parameter  int MAX_NODES_PER_SIDE = cgbm_pkg::MAX_NODES_DEF,
	parameter  int COORD_WIDTH        = cgbm_pkg::COORD_WIDTH_DEF,
	parameter  int FRAC_BITS          = cgbm_pkg::FRAC_BITS_DEF,
	localparam int ADDR_W             = $clog2(MAX_NODES_PER_SIDE * MAX_NODES_PER_SIDE)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cgbm_pkg::cmd_t                cmd,
	input  logic                          mem_we,
	input  logic [ADDR_W-1:0]             mem_addr,
	input  logic signed [COORD_WIDTH-1:0] wr_data,
	input  logic                          rd_oob,
	input  logic [FRAC_BITS:0]            weight,
	output logic signed [COORD_WIDTH-1:0] result
);
	import cgbm_pkg::*;

	localparam int DEPTH = MAX_NODES_PER_SIDE * MAX_NODES_PER_SIDE;
	localparam int AW    = COORD_WIDTH + 2;
	localparam int PW    = AW + FRAC_BITS + 2;
	localparam int ACCW  = COORD_WIDTH + 4;
	localparam logic signed [ACCW-1:0] SAT_HI =
		{{(ACCW-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
	localparam logic signed [ACCW-1:0] SAT_LO =
		{{(ACCW-COORD_WIDTH+1){1'b1}}, {(COORD_WIDTH-1){1'b0}}};

	logic signed [COORD_WIDTH-1:0] mem [DEPTH];
	logic signed [COORD_WIDTH-1:0] rd_q;
	logic                          cap_s1;
	rd_sel_t                       sel_s1;
	logic                          oob_s1;
	logic signed [COORD_WIDTH-1:0] p00_q, p10_q, p01_q, p11_q;
	logic signed [AW-1:0]          a_q, b_q, c_q, e_q, tmp_q;
	logic signed [AW-1:0]          op_a;
	logic signed [FRAC_BITS+1:0]   op_w;
	logic signed [PW-1:0]          prod_q;
	logic signed [AW-1:0]          trunc;
	logic signed [ACCW-1:0]        acc_q;
	logic signed [COORD_WIDTH-1:0] sat;
	logic signed [COORD_WIDTH-1:0] out_q;

	// single port: writes only on loads, reads only during a query
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_addr] <= wr_data;
		if (cmd.rd_en)
			rd_q <= mem[mem_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cap_s1 <= 1'b0;
		else
			cap_s1 <= cmd.rd_en;
	end

	always_ff @(posedge clk) begin
		sel_s1 <= cmd.rd_sel;
		oob_s1 <= rd_oob;
		if (cap_s1) begin
			case (sel_s1)
				RD_00: p00_q <= oob_s1 ? '0 : rd_q;
				RD_10: p10_q <= oob_s1 ? '0 : rd_q;
				RD_01: p01_q <= oob_s1 ? '0 : rd_q;
				RD_11: p11_q <= oob_s1 ? '0 : rd_q;
				default: ;
			endcase
		end
		if (cmd.diff) begin
			b_q <= AW'(p10_q) - AW'(p00_q);
			c_q <= AW'(p01_q) - AW'(p00_q);
			e_q <= AW'(p11_q) - AW'(p01_q);
		end
		if (cmd.areg)
			a_q <= e_q - b_q;
	end

	always_comb begin
		case (cmd.opa)
			OPA_P00: op_a = AW'(p00_q);
			OPA_P10: op_a = AW'(p10_q);
			OPA_P01: op_a = AW'(p01_q);
			OPA_A:   op_a = a_q;
			OPA_B:   op_a = b_q;
			OPA_C:   op_a = c_q;
			OPA_TMP: op_a = tmp_q;
			default: op_a = AW'(p00_q);
		endcase
	end

	assign op_w  = $signed({1'b0, weight});
	// floor shift; weight never exceeds one, so the result fits AW bits
	assign trunc = $signed(prod_q[AW+FRAC_BITS-1:FRAC_BITS]);

	always_comb begin
		if (acc_q > SAT_HI)
			sat = SAT_HI[COORD_WIDTH-1:0];
		else if (acc_q < SAT_LO)
			sat = SAT_LO[COORD_WIDTH-1:0];
		else
			sat = acc_q[COORD_WIDTH-1:0];
	end

	always_ff @(posedge clk) begin
		prod_q <= op_a * op_w;
		case (cmd.acc)
			ACC_CLR: acc_q <= '0;
			ACC_P00: acc_q <= ACCW'(p00_q);
			ACC_ADD: acc_q <= acc_q + ACCW'(trunc);
			ACC_TMP: tmp_q <= trunc;
			default: ;
		endcase
		if (cmd.out_load)
			out_q <= sat;
	end

	assign result = out_q;

endmodule

/* rtl/core/cgbm_datapath.sv */
// Datapath of the grid map block: cell count registers, index clamp,
// node addressing and weights, and the x and y lanes. Depends on cgbm_pkg.
module cgbm_datapath #(
	parameter int MAX_NODES_PER_SIDE = cgbm_pkg::MAX_NODES_DEF,
	parameter int COORD_WIDTH        = cgbm_pkg::COORD_WIDTH_DEF,
	parameter int FRAC_BITS          = cgbm_pkg::FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  cgbm_pkg::cmd_t                     cmd,
	output cgbm_pkg::status_t                  status,
	input  logic                               cfg_wr_en,
	input  logic [cgbm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [cgbm_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic [cgbm_pkg::CELL_W-1:0]        node_col,
	input  logic [cgbm_pkg::CELL_W-1:0]        node_row,
	input  logic signed [COORD_WIDTH-1:0]      node_xcoord,
	input  logic signed [COORD_WIDTH-1:0]      node_ycoord,
	input  logic signed [cgbm_pkg::IDX_W-1:0]  frac_i,
	input  logic signed [cgbm_pkg::IDX_W-1:0]  frac_j,
	output logic signed [COORD_WIDTH-1:0]      out_x,
	output logic signed [COORD_WIDTH-1:0]      out_y,
	output logic                               in_range
);
	import cgbm_pkg::*;

	localparam int ADDR_W = $clog2(MAX_NODES_PER_SIDE * MAX_NODES_PER_SIDE);
	localparam int FCW    = CELL_W + FRAC_BITS;
	localparam int IW1    = IDX_W + 1;
	localparam int PW     = CELL_W + 1;
	localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

	logic [CELL_W-1:0]    cells_i_q, cells_j_q;
	logic [CELL_W-1:0]    eff_i, eff_j;
	logic signed [IW1-1:0] fi_w, fj_w, lim_i, lim_j;
	logic [FCW-1:0]       fci, fcj;
	logic                 ok_i, ok_j;
	logic [CELL_W-1:0]    i_q, j_q;
	logic [FRAC_BITS-1:0] u_q, v_q;
	logic                 ok_q, in_range_q;
	logic [PW-1:0]        rd_col, rd_row;
	logic                 rd_oob, wr_oob;
	logic [ADDR_W-1:0]    rd_addr, wr_addr, mem_addr;
	logic                 mem_we;
	logic [FRAC_BITS:0]   weight;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cells_i_q <= CELLS_RESET;
			cells_j_q <= CELLS_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_CELLS_I: cells_i_q <= cfg_data;
				CFG_CELLS_J: cells_j_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// a count of zero acts as one cell
	assign eff_i = (cells_i_q == '0) ? CELL_W'(1) : cells_i_q;
	assign eff_j = (cells_j_q == '0) ? CELL_W'(1) : cells_j_q;
	assign lim_i = IW1'({eff_i, {FRAC_BITS{1'b0}}});
	assign lim_j = IW1'({eff_j, {FRAC_BITS{1'b0}}});
	assign fi_w  = IW1'(frac_i);
	assign fj_w  = IW1'(frac_j);

	always_comb begin
		ok_i = 1'b1;
		if (fi_w < 0) begin
			fci  = '0;
			ok_i = 1'b0;
		end else if (fi_w > lim_i) begin
			fci  = lim_i[FCW-1:0] - FCW'(1);
			ok_i = 1'b0;
		end else begin
			fci = fi_w[FCW-1:0];
		end
	end

	always_comb begin
		ok_j = 1'b1;
		if (fj_w < 0) begin
			fcj  = '0;
			ok_j = 1'b0;
		end else if (fj_w > lim_j) begin
			fcj  = lim_j[FCW-1:0] - FCW'(1);
			ok_j = 1'b0;
		end else begin
			fcj = fj_w[FCW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			i_q  <= fci[FCW-1:FRAC_BITS];
			j_q  <= fcj[FCW-1:FRAC_BITS];
			u_q  <= fci[FRAC_BITS-1:0];
			v_q  <= fcj[FRAC_BITS-1:0];
			ok_q <= ok_i && ok_j;
		end
		if (cmd.out_load)
			in_range_q <= ok_q;
	end

	assign status.u_zero = (u_q == '0);
	assign status.v_zero = (v_q == '0);

	always_comb begin
		case (cmd.opw)
			W_U:     weight = {1'b0, u_q};
			W_V:     weight = {1'b0, v_q};
			W_ONE_U: weight = ONE - {1'b0, u_q};
			W_ONE_V: weight = ONE - {1'b0, v_q};
			default: weight = {1'b0, u_q};
		endcase
	end

	assign rd_col  = {1'b0, i_q} + PW'(cmd.rd_sel == RD_10 || cmd.rd_sel == RD_11);
	assign rd_row  = {1'b0, j_q} + PW'(cmd.rd_sel == RD_01 || cmd.rd_sel == RD_11);
	assign rd_oob  = (int'(rd_col) >= MAX_NODES_PER_SIDE) ||
	                 (int'(rd_row) >= MAX_NODES_PER_SIDE);
	assign rd_addr = ADDR_W'(int'(rd_row) * MAX_NODES_PER_SIDE + int'(rd_col));
	assign wr_oob  = (int'(node_col) >= MAX_NODES_PER_SIDE) ||
	                 (int'(node_row) >= MAX_NODES_PER_SIDE);
	assign wr_addr = ADDR_W'(int'(node_row) * MAX_NODES_PER_SIDE + int'(node_col));

	assign mem_we   = cmd.write && !wr_oob;
	assign mem_addr = cmd.write ? wr_addr : rd_addr;

	cgbm_lane #(
		.MAX_NODES_PER_SIDE (MAX_NODES_PER_SIDE),
		.COORD_WIDTH        (COORD_WIDTH),
		.FRAC_BITS          (FRAC_BITS)
	) u_lane_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.mem_we   (mem_we),
		.mem_addr (mem_addr),
		.wr_data  (node_xcoord),
		.rd_oob   (rd_oob),
		.weight   (weight),
		.result   (out_x)
	);

	cgbm_lane #(
		.MAX_NODES_PER_SIDE (MAX_NODES_PER_SIDE),
		.COORD_WIDTH        (COORD_WIDTH),
		.FRAC_BITS          (FRAC_BITS)
	) u_lane_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.mem_we   (mem_we),
		.mem_addr (mem_addr),
		.wr_data  (node_ycoord),
		.rd_oob   (rd_oob),
		.weight   (weight),
		.result   (out_y)
	);

	assign in_range = in_range_q;

endmodule

/* rtl/core/curvilinear_grid_bilinear_map_top.sv */
// Top level of the curvilinear grid bilinear map block.
// Depends on cgbm_pkg, cgbm_if, cgbm_ctrl and cgbm_datapath.
//
// Usage: software first loads every grid node with req_type = 0 words on
// the req channel (col, row, x, y), then sends req_type = 1 query words with
// Q16.16 fractional indices frac_i, frac_j. Each query gives one word on the
// res channel: out_x, out_y and in_range; a load gives none.
// Loads are written as they are accepted; req.ready stays high after a load.
// A query drops req.ready while the four corner nodes are read in turn from
// the single-port x and y stores and the per-lane multiplier runs its steps:
// none when both fractions are zero, a shorter run when one is zero, the full
// run otherwise. The next word is taken once the result has been loaded into
// the output register.
// The result sits in an output register; further words are accepted while
// it waits. If the receiver still stalls when the next query finishes, that
// query holds its result until the register frees.
// Reset clears the sequencer and output valid and sets both cell counts to
// 63; node stores are undefined until loaded. cfg_wr_en writes cell counts
// and is meant for idle periods only.
module curvilinear_grid_bilinear_map_top #(
	parameter int MAX_NODES_PER_SIDE = cgbm_pkg::MAX_NODES_DEF,
	parameter int COORD_WIDTH        = cgbm_pkg::COORD_WIDTH_DEF,
	parameter int FRAC_BITS          = cgbm_pkg::FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	cgbm_req_if.sink                        req,
	cgbm_res_if.source                      res,
	input  logic                            cfg_wr_en,
	input  logic [cgbm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cgbm_pkg::CFG_DATA_W-1:0] cfg_data
);
	import cgbm_pkg::*;

	cmd_t    cmd;
	status_t status;

	cgbm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_is_map (req.req_type == REQ_MAP),
		.out_ready (res.ready),
		.status    (status),
		.in_ready  (req.ready),
		.out_valid (res.valid),
		.cmd       (cmd)
	);

	cgbm_datapath #(
		.MAX_NODES_PER_SIDE (MAX_NODES_PER_SIDE),
		.COORD_WIDTH        (COORD_WIDTH),
		.FRAC_BITS          (FRAC_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.node_col    (req.node_col),
		.node_row    (req.node_row),
		.node_xcoord (req.node_xcoord),
		.node_ycoord (req.node_ycoord),
		.frac_i      (req.frac_i),
		.frac_j      (req.frac_j),
		.out_x       (res.out_x),
		.out_y       (res.out_y),
		.in_range    (res.in_range)
	);

endmodule

/* rtl/core/cgbm_checker.sv */
// Port-level checker for the grid map block, bound to the top level.
// Depends on cgbm_pkg for request type codes.
module cgbm_checker (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic req_type,
	input logic res_valid,
	input logic res_ready
);
	import cgbm_pkg::*;

	logic load_acc, map_acc;

	assign load_acc = req_valid && req_ready && (req_type == REQ_LOAD);
	assign map_acc  = req_valid && req_ready && (req_type == REQ_MAP);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result word dropped while stalled");

	a_map_busy: assert property (@(posedge clk) disable iff (!arst_n)
		map_acc |=> !req_ready)
		else $error("query accepted but request channel still ready");

	a_load_fast: assert property (@(posedge clk) disable iff (!arst_n)
		load_acc |=> req_ready)
		else $error("load did not complete in one cycle");

	a_load_no_res: assert property (@(posedge clk) disable iff (!arst_n)
		load_acc |=> !$rose(res_valid))
		else $error("result word appeared after a load");

endmodule

bind curvilinear_grid_bilinear_map_top cgbm_checker u_cgbm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.req_type  (req.req_type),
	.res_valid (res.valid),
	.res_ready (res.ready)
);
